@@ rtl/core/audio_rms_level_meter_unit_defines.svh @@
// Assertion macros shared by the audio RMS level meter RTL.
`ifndef AUDIO_RMS_LEVEL_METER_UNIT_DEFINES_SVH
`define AUDIO_RMS_LEVEL_METER_UNIT_DEFINES_SVH

`ifndef SYNTHESIS
`define ARLM_ASSERT_IMP(lbl, cond, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (cond) |-> (prop)) \
    else $error("level meter check failed");
`define ARLM_ASSERT_NXT(lbl, cond, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (cond) |=> (prop)) \
    else $error("level meter check failed");
`else
`define ARLM_ASSERT_IMP(lbl, cond, prop)
`define ARLM_ASSERT_NXT(lbl, cond, prop)
`endif

`endif

@@ rtl/core/arlm_pkg.sv @@
// Constants and types of the audio RMS level meter.
package arlm_pkg;

  localparam int unsigned MAX_FRAMES  = 1024;
  localparam int unsigned SAMPLE_W    = 16;
  localparam int unsigned RMS_W       = 16;
  localparam int unsigned LEVEL_W     = 24;
  localparam int unsigned CNT_W       = $clog2(MAX_FRAMES + 1);
  localparam int unsigned SUM_W       = $clog2(MAX_FRAMES) + 32;
  localparam int unsigned SQR_W       = 2 * SAMPLE_W;
  localparam int unsigned MEAN_W      = 2 * RMS_W;
  localparam int unsigned SQREM_W     = RMS_W + 4;
  localparam int unsigned NUM_W       = LEVEL_W + 4;
  localparam int unsigned STEP_W      = $clog2(SUM_W + 1);
  localparam int unsigned DIV10_W     = 4;
  localparam int unsigned SMOOTH_DIV  = 10;
  localparam int unsigned SMOOTH_RND  = 5;
  localparam int unsigned OUT_TDATA_W = ((RMS_W + LEVEL_W + 7) / 8) * 8;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SQUARE,
    ST_DIVIDE,
    ST_ROOT,
    ST_SCALE,
    ST_SUM,
    ST_DIV10,
    ST_EMIT
  } state_t;

endpackage

@@ rtl/core/audio_rms_level_meter_unit.sv @@
// Audio RMS level meter with bit-serial square, divide, root and smoothing.
// A sample that is not the last of its frame is accepted in ST_IDLE and then squared in serial
// steps, one per multiplier bit, before the next accept; a dropped sample leaves it in ST_IDLE.
// A final sample is squared unless it is dropped, then goes through the serial divide of the frame sum,
// the serial square root, ST_SCALE and ST_SUM, the serial divide by ten and the load in ST_EMIT.
// The serial divider of the frame sum takes the most steps; ST_EMIT waits while the output is stalled.
// rst_n is synchronous and active low; it clears the sums, the count and the smoothed level.
`include "audio_rms_level_meter_unit_defines.svh"

module audio_rms_level_meter_unit (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               in_tvalid,
  output logic                               in_tready,
  input  logic [arlm_pkg::SAMPLE_W-1:0]      in_tdata,   // [15:0] sample (signed)
  input  logic                               in_tlast,   // frame_last
  output logic                               out_tvalid,
  input  logic                               out_tready,
  output logic [arlm_pkg::OUT_TDATA_W-1:0]   out_tdata,  // [15:0] rms_level, [39:16] smoothed_level
  output logic                               out_tuser   // frame_too_long
);

  localparam int unsigned SW = arlm_pkg::SUM_W;
  localparam int unsigned CW = arlm_pkg::CNT_W;
  localparam int unsigned NW = arlm_pkg::NUM_W;
  localparam int unsigned QW = arlm_pkg::SQREM_W;
  localparam int unsigned RW = arlm_pkg::RMS_W;
  localparam int unsigned LW = arlm_pkg::LEVEL_W;
  localparam int unsigned TW = arlm_pkg::STEP_W;
  localparam int unsigned DW = arlm_pkg::DIV10_W;

  arlm_pkg::state_t state_r, state_nxt;

  logic [SW-1:0]                    sum_r;
  logic [CW-1:0]                    cnt_r;
  logic [CW-1:0]                    rem_r;
  logic                             ovf_r;
  logic                             last_r;
  logic [TW-1:0]                    step_r;
  logic [arlm_pkg::SQR_W-1:0]       mcand_r;
  logic [arlm_pkg::SAMPLE_W-1:0]    mplier_r;
  logic [QW-1:0]                    sq_rem_r;
  logic [RW-1:0]                    root_r;
  logic [NW-1:0]                    num_r;
  logic [NW-1:0]                    add_r;
  logic [DW-1:0]                    rem10_r;
  logic [LW-1:0]                    level_avg_r;
  logic                             out_tvalid_r;
  logic [RW-1:0]                    out_rms_r;
  logic [LW-1:0]                    out_level_r;
  logic                             out_long_r;

  logic                             in_fire;
  logic                             cnt_ok;
  logic                             step_done;
  logic                             out_free;
  logic                             out_load;
  logic [arlm_pkg::SAMPLE_W-1:0]    mag;
  logic [CW:0]                      div_cand;
  logic                             div_ge;
  logic [QW-1:0]                    sq_cand;
  logic [QW-1:0]                    sq_trial;
  logic                             sq_ge;
  logic [DW:0]                      d10_cand;
  logic                             d10_ge;
  logic [LW-1:0]                    level_new;

  assign in_fire   = in_tvalid && in_tready;
  assign cnt_ok    = cnt_r < CW'(arlm_pkg::MAX_FRAMES);
  assign step_done = (step_r == '0);
  assign out_free  = !out_tvalid_r || out_tready;
  assign mag       = in_tdata[arlm_pkg::SAMPLE_W-1] ? (~in_tdata + 1'b1) : in_tdata;

  assign div_cand = {rem_r, sum_r[SW-1]};
  assign div_ge   = div_cand >= {1'b0, cnt_r};

  assign sq_cand  = {sq_rem_r[QW-3:0], sum_r[arlm_pkg::MEAN_W-1 -: 2]};
  assign sq_trial = QW'({root_r, 2'b01});
  assign sq_ge    = sq_cand >= sq_trial;

  assign d10_cand = {rem10_r, num_r[NW-1]};
  assign d10_ge   = d10_cand >= (DW + 1)'(arlm_pkg::SMOOTH_DIV);

  assign level_new = (num_r > NW'({LW{1'b1}})) ? {LW{1'b1}} : num_r[LW-1:0];

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      arlm_pkg::ST_IDLE: begin
        if (in_fire) begin
          if (cnt_ok) begin
            state_nxt = arlm_pkg::ST_SQUARE;
          end else if (in_tlast) begin
            state_nxt = arlm_pkg::ST_DIVIDE;
          end
        end
      end
      arlm_pkg::ST_SQUARE: begin
        if (step_done) begin
          state_nxt = last_r ? arlm_pkg::ST_DIVIDE : arlm_pkg::ST_IDLE;
        end
      end
      arlm_pkg::ST_DIVIDE: begin
        if (step_done) begin
          state_nxt = arlm_pkg::ST_ROOT;
        end
      end
      arlm_pkg::ST_ROOT: begin
        if (step_done) begin
          state_nxt = arlm_pkg::ST_SCALE;
        end
      end
      arlm_pkg::ST_SCALE: begin
        state_nxt = arlm_pkg::ST_SUM;
      end
      arlm_pkg::ST_SUM: begin
        state_nxt = arlm_pkg::ST_DIV10;
      end
      arlm_pkg::ST_DIV10: begin
        if (step_done) begin
          state_nxt = arlm_pkg::ST_EMIT;
        end
      end
      arlm_pkg::ST_EMIT: begin
        if (out_free) begin
          state_nxt = arlm_pkg::ST_IDLE;
        end
      end
      default: begin
        state_nxt = arlm_pkg::ST_IDLE;
      end
    endcase
  end

  always_comb begin
    in_tready = (state_r == arlm_pkg::ST_IDLE);
    out_load  = (state_r == arlm_pkg::ST_EMIT) && out_free;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= arlm_pkg::ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sum_r        <= '0;
      cnt_r        <= '0;
      ovf_r        <= 1'b0;
      level_avg_r  <= '0;
      out_tvalid_r <= 1'b0;
    end else begin
      if (out_tready) begin
        out_tvalid_r <= 1'b0;
      end
      case (state_r)
        arlm_pkg::ST_IDLE: begin
          rem_r <= '0;
          if (in_fire) begin
            last_r   <= in_tlast;
            mplier_r <= mag;
            mcand_r  <= arlm_pkg::SQR_W'(mag);
            if (cnt_ok) begin
              cnt_r  <= cnt_r + 1'b1;
              step_r <= TW'(arlm_pkg::SAMPLE_W - 1);
            end else begin
              ovf_r  <= 1'b1;
              step_r <= TW'(SW - 1);
            end
          end
        end
        arlm_pkg::ST_SQUARE: begin
          rem_r <= '0;
          if (mplier_r[0]) begin
            sum_r <= sum_r + SW'(mcand_r);
          end
          mcand_r  <= mcand_r << 1;
          mplier_r <= mplier_r >> 1;
          step_r   <= step_done ? TW'(SW - 1) : step_r - 1'b1;
        end
        arlm_pkg::ST_DIVIDE: begin
          rem_r    <= div_ge ? CW'(div_cand - {1'b0, cnt_r}) : div_cand[CW-1:0];
          sum_r    <= {sum_r[SW-2:0], div_ge};
          sq_rem_r <= '0;
          root_r   <= '0;
          step_r   <= step_done ? TW'(RW - 1) : step_r - 1'b1;
        end
        arlm_pkg::ST_ROOT: begin
          sq_rem_r <= sq_ge ? (sq_cand - sq_trial) : sq_cand;
          root_r   <= {root_r[RW-2:0], sq_ge};
          sum_r    <= sum_r << 2;
          step_r   <= step_r - 1'b1;
        end
        arlm_pkg::ST_SCALE: begin
          num_r <= NW'({level_avg_r, 3'b000}) - NW'(level_avg_r);
          add_r <= NW'({root_r, 9'b0}) + NW'({root_r, 8'b0}) + NW'(arlm_pkg::SMOOTH_RND);
        end
        arlm_pkg::ST_SUM: begin
          num_r   <= num_r + add_r;
          rem10_r <= '0;
          step_r  <= TW'(NW - 1);
        end
        arlm_pkg::ST_DIV10: begin
          rem10_r <= d10_ge ? DW'(d10_cand - (DW + 1)'(arlm_pkg::SMOOTH_DIV))
                            : d10_cand[DW-1:0];
          num_r   <= {num_r[NW-2:0], d10_ge};
          step_r  <= step_r - 1'b1;
        end
        arlm_pkg::ST_EMIT: begin
          if (out_load) begin
            out_tvalid_r <= 1'b1;
            out_rms_r    <= root_r;
            out_level_r  <= level_new;
            out_long_r   <= ovf_r;
            level_avg_r  <= level_new;
            sum_r        <= '0;
            cnt_r        <= '0;
            ovf_r        <= 1'b0;
          end
        end
        default: begin
        end
      endcase
    end
  end

  assign out_tvalid = out_tvalid_r;
  assign out_tdata  = arlm_pkg::OUT_TDATA_W'({out_level_r, out_rms_r});
  assign out_tuser  = out_long_r;

  `ARLM_ASSERT_IMP(a_cnt_bound, 1'b1, cnt_r <= CW'(arlm_pkg::MAX_FRAMES))
  `ARLM_ASSERT_IMP(a_div_nonzero, state_r == arlm_pkg::ST_DIVIDE, cnt_r != '0)
  `ARLM_ASSERT_IMP(a_root_bound, state_r == arlm_pkg::ST_SCALE, root_r <= 16'h8000)
  `ARLM_ASSERT_NXT(a_drop_keeps_cnt, in_fire && !cnt_ok, $stable(cnt_r))

endmodule

@@ sim/audio_rms_level_meter_unit_tb.sv @@
// Self-checking testbench of the audio RMS level meter: framed samples in, level results checked.
`timescale 1ns / 1ps

module audio_rms_level_meter_unit_tb;

  localparam int unsigned CYCLE_LIMIT = 2000000;
  localparam int unsigned DRAIN_CYCLES = 300;
  localparam int unsigned LONG_FRAME_LEN = arlm_pkg::MAX_FRAMES + 2;
  localparam int unsigned RANDOM_SAMPLES = 404;

  typedef struct packed {
    logic [arlm_pkg::RMS_W-1:0]   rms;
    logic [arlm_pkg::LEVEL_W-1:0] level;
    logic                         too_long;
  } meter_result_t;

  typedef struct {
    logic [arlm_pkg::SAMPLE_W-1:0] sample;
    logic                          last;
    bit                            hold;
  } audio_item_t;

  typedef enum int {
    MIX_FULL_RANGE,
    MIX_QUIET,
    MIX_EXTREMES,
    MIX_LOUD
  } sample_mix_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_tvalid = 1'b0;
  logic in_tready;
  logic [arlm_pkg::SAMPLE_W-1:0] in_tdata = '0;
  logic in_tlast = 1'b0;
  logic out_tvalid;
  logic out_tready = 1'b0;
  logic [arlm_pkg::OUT_TDATA_W-1:0] out_tdata;
  logic out_tuser;

  audio_item_t   pending_items[$];
  meter_result_t level_results_due[$];

  logic [63:0]                  meter_sum = '0;
  int unsigned                  meter_count = 0;
  logic [arlm_pkg::LEVEL_W-1:0] meter_level = '0;
  bit                           meter_dropped = 1'b0;

  logic        nothing_pending = 1'b1;
  int          mismatches = 0;
  int          samples_sent = 0;
  int          frames_seen = 0;
  int          long_frames_seen = 0;
  int          send_gap = 0;
  int          stall_left = 0;
  int unsigned cycle_count = 0;
  audio_item_t   next_item;
  meter_result_t got_result;
  meter_result_t want_result;

  audio_rms_level_meter_unit u_top (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .in_tlast  (in_tlast),
    .out_tvalid(out_tvalid),
    .out_tready(out_tready),
    .out_tdata (out_tdata),
    .out_tuser (out_tuser)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  function automatic int pick_gap(input bit steady);
    int roll;
    if (steady) return 0;
    roll = $urandom_range(0, 99);
    if (roll < 55) return 0;
    if (roll < 93) return $urandom_range(1, 3);
    return $urandom_range(10, 40);
  endfunction

  function automatic bit meter_predict(input logic [arlm_pkg::SAMPLE_W-1:0] sample,
                                       input logic last, output meter_result_t res);
    logic [16:0] mag;
    logic [63:0] mean;
    logic [16:0] root;
    logic [16:0] trial;
    logic [63:0] next_level;
    mag = sample[15] ? (17'h10000 - {1'b0, sample}) : {1'b0, sample};
    if (meter_count < arlm_pkg::MAX_FRAMES) begin
      meter_sum = meter_sum + 64'(mag) * 64'(mag);
      meter_count++;
    end else begin
      meter_dropped = 1'b1;
    end
    res = '0;
    if (!last) return 1'b0;
    mean = (meter_count != 0) ? meter_sum / 64'(meter_count) : 64'd0;
    root = '0;
    for (int b = 15; b >= 0; b--) begin
      trial = root | (17'd1 << b);
      if (64'(trial) * 64'(trial) <= mean) root = trial;
    end
    next_level = (64'(meter_level) * 7 + 64'(root) * 768 + 5) / 10;
    if (next_level > 64'hFFFFFF) next_level = 64'hFFFFFF;
    meter_level = next_level[23:0];
    res.rms = root[15:0];
    res.level = meter_level;
    res.too_long = meter_dropped;
    meter_sum = '0;
    meter_count = 0;
    meter_dropped = 1'b0;
    return 1'b1;
  endfunction

  task automatic report_mismatch(input string what, input longint unsigned got,
                                 input longint unsigned want);
    mismatches++;
    $display("ERROR %s: got %0d, expected %0d", what, got, want);
  endtask

  task automatic add_sample(input logic [arlm_pkg::SAMPLE_W-1:0] sample, input logic last);
    audio_item_t it;
    it.sample = sample;
    it.last = last;
    it.hold = 1'b0;
    pending_items = {pending_items, it};
  endtask

  task automatic add_hold();
    audio_item_t it;
    it.sample = '0;
    it.last = 1'b0;
    it.hold = 1'b1;
    pending_items = {pending_items, it};
  endtask

  function automatic logic [15:0] pick_sample(input sample_mix_t mix);
    logic [15:0] v;
    case (mix)
      MIX_QUIET: begin
        v = 16'($signed($urandom_range(0, 511)) - 256);
      end
      MIX_EXTREMES: begin
        case ($urandom_range(0, 4))
          0: v = 16'h8000;
          1: v = 16'h7FFF;
          2: v = 16'h8001;
          3: v = 16'h0000;
          default: v = 16'hFFFF;
        endcase
      end
      MIX_LOUD: begin
        v = $urandom_range(0, 1) ? 16'($urandom_range(16'h7000, 16'h7FFF))
                                 : 16'($urandom_range(16'h8000, 16'h8FFF));
      end
      default: begin
        v = 16'($urandom);
      end
    endcase
    return v;
  endfunction

  always @(posedge clk) begin
    if (!rst_n) begin
      in_tvalid <= 1'b0;
      in_tdata <= '0;
      in_tlast <= 1'b0;
      send_gap = 0;
    end else begin
      if (in_tvalid && in_tready) begin
        samples_sent++;
        send_gap = pick_gap(samples_sent[7:6] == 2'b11);
      end
      if (!in_tvalid || in_tready) begin
        if (send_gap > 0) begin
          send_gap--;
          in_tvalid <= 1'b0;
        end else if (pending_items.size() == 0) begin
          in_tvalid <= 1'b0;
        end else if (pending_items[0].hold) begin
          if (!in_tvalid && nothing_pending) pending_items.delete(0);
          in_tvalid <= 1'b0;
        end else begin
          next_item = pending_items.pop_front();
          in_tvalid <= 1'b1;
          in_tdata <= next_item.sample;
          in_tlast <= next_item.last;
        end
      end
    end
  end

  always @(posedge clk) begin
    if (!rst_n) begin
      out_tready <= 1'b0;
      stall_left = 0;
      nothing_pending <= 1'b1;
    end else begin
      if (in_tvalid && in_tready) begin
        if (meter_predict(in_tdata, in_tlast, want_result)) begin
          level_results_due = {level_results_due, want_result};
        end
      end
      if (out_tvalid && out_tready) begin
        frames_seen++;
        if (out_tuser) long_frames_seen++;
        got_result.rms = out_tdata[15:0];
        got_result.level = out_tdata[39:16];
        got_result.too_long = out_tuser;
        if (level_results_due.size() == 0) begin
          report_mismatch("result transaction with none expected, rms", got_result.rms, 0);
        end else begin
          want_result = level_results_due.pop_front();
          if (got_result.rms !== want_result.rms) begin
            report_mismatch("rms_level", got_result.rms, want_result.rms);
          end
          if (got_result.level !== want_result.level) begin
            report_mismatch("smoothed_level", got_result.level, want_result.level);
          end
          if (got_result.too_long !== want_result.too_long) begin
            report_mismatch("frame_too_long", got_result.too_long, want_result.too_long);
          end
        end
        stall_left = pick_gap(frames_seen[3:2] == 2'b11);
      end else if (!out_tvalid && stall_left == 0 && $urandom_range(0, 15) == 0) begin
        stall_left = pick_gap(1'b0);
      end
      if (stall_left > 0) begin
        stall_left--;
        out_tready <= 1'b0;
      end else begin
        out_tready <= 1'b1;
      end
      nothing_pending <= (level_results_due.size() == 0);
    end
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("timeout after %0d cycles", cycle_count);
      $display("audio_rms_level_meter_unit: mismatch");
      $finish;
    end
  end

  initial begin
    int random_samples;
    int frame_len;
    sample_mix_t mix;

    // Single-sample frames at the field extremes, then a few short frames.
    add_sample(16'h0000, 1'b1);
    add_sample(16'h7FFF, 1'b1);
    add_sample(16'h8000, 1'b1);
    add_sample(16'hFFFF, 1'b1);
    add_sample(16'h0001, 1'b1);
    add_sample(16'h8001, 1'b1);
    add_sample(16'h0003, 1'b0);
    add_sample(16'h0004, 1'b1);
    add_sample(16'h8000, 1'b0);
    add_sample(16'h7FFF, 1'b0);
    add_sample(16'h0000, 1'b1);
    add_sample(16'h5555, 1'b0);
    add_sample(16'hAAAA, 1'b0);
    add_sample(16'h00FF, 1'b0);
    add_sample(16'hFF00, 1'b1);
    add_sample(16'h0000, 1'b0);
    add_sample(16'h0000, 1'b0);
    add_sample(16'h0002, 1'b1);
    add_hold();

    // Full-scale frame past the length limit; the dropped tail includes the last sample.
    for (int k = 0; k < LONG_FRAME_LEN; k++) begin
      add_sample((k == LONG_FRAME_LEN - 1) ? 16'($urandom) : 16'h8000,
                 k == LONG_FRAME_LEN - 1);
    end
    add_sample(16'h8000, 1'b1);
    add_hold();

    random_samples = 0;
    while (random_samples < RANDOM_SAMPLES) begin
      frame_len = ($urandom_range(0, 9) < 8) ? $urandom_range(1, 8) : $urandom_range(9, 40);
      mix = sample_mix_t'($urandom_range(0, 3));
      for (int k = 0; k < frame_len; k++) begin
        add_sample(pick_sample(mix), k == frame_len - 1);
      end
      random_samples += frame_len;
      if (random_samples >= RANDOM_SAMPLES / 2 && random_samples - frame_len < RANDOM_SAMPLES / 2)
        add_hold();
    end

    repeat (12) @(posedge clk);
    rst_n <= 1'b1;

    @(negedge clk);
    while (pending_items.size() != 0 || in_tvalid || level_results_due.size() != 0) begin
      @(negedge clk);
    end
    repeat (DRAIN_CYCLES) @(negedge clk);

    while (level_results_due.size() != 0) begin
      want_result = level_results_due.pop_front();
      report_mismatch("result never arrived, rms", 0, want_result.rms);
    end
    $display("Sent %0d samples; checked %0d frame results, %0d of them over the length limit.",
             samples_sent, frames_seen, long_frames_seen);
    $display("Covered full-scale extremes, dropped samples and random short frames.");
    if (mismatches == 0) begin
      $display("audio_rms_level_meter_unit: match");
    end else begin
      $display("audio_rms_level_meter_unit: mismatch");
    end
    $finish;
  end

endmodule
